// ===== rtl/bbl_pkg.sv =====
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types and codes for the brace byte-list parser: result kinds and
// the record that the front hands to the back through the queue.
// ----------------------------------------------------------------------------
package bbl_pkg;

    // result kinds on the output channel
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // work for the back: an optional byte, then an optional end marker
    typedef struct packed {
        logic       has_byte;
        logic [7:0] value;
        logic       has_end;
        logic       end_ok;
    } op_t;

endpackage

// ===== rtl/bbl_front.sv =====
// ----------------------------------------------------------------------------
// bbl_front
// Accepts one character per cycle unless the queue is full, runs the list
// grammar and pushes a record when the character ends a byte or the string.
// ----------------------------------------------------------------------------
module bbl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    character_code,
    input  logic          last_character,
    input  logic          q_full,
    output logic          push,
    output bbl_pkg::op_t  push_op
);
    import bbl_pkg::*;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [11:0] BYTE_MAX = 12'd255;

    typedef enum logic [3:0] {
        PH_INIT       = 4'd0,
        PH_NEXT_VALUE = 4'd1,
        PH_DEC_VALUE  = 4'd2,
        PH_HEX_0      = 4'd3,
        PH_HEX_X      = 4'd4,
        PH_HEX_VALUE  = 4'd5,
        PH_VALUE_FIN  = 4'd6,
        PH_ERROR      = 4'd7,
        PH_FIN        = 4'd8
    } phase_t;

    // digit value in bit 3:0, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c inside {[CH_ZERO:CH_NINE]})
            d = 5'(c - CH_ZERO);
        else if (c inside {[CH_LOW_A:CH_LOW_F]})
            d = 5'(c - CH_LOW_A + 8'd10);
        else if (c inside {[CH_UP_A:CH_UP_F]})
            d = 5'(c - CH_UP_A + 8'd10);
        return d;
    endfunction

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      phase_step;
    logic [7:0]  acc_reg;
    logic [7:0]  acc_next;
    logic [7:0]  acc_step;
    logic        accept;
    logic        emit;
    logic [4:0]  hex_d;
    logic        is_dec;
    logic        digit_ok;
    logic [11:0] wide;

    assign accept = in_valid && !q_full;
    assign hex_d  = hex_digit(character_code);
    assign is_dec = character_code inside {[CH_ZERO:CH_NINE]};

    // fold the next digit into the value, base by phase
    always_comb
    begin
        if (phase_reg == PH_HEX_VALUE)
        begin
            digit_ok = !hex_d[4];
            wide     = {acc_reg, 4'b0000} + {8'd0, hex_d[3:0]};
        end
        else
        begin
            digit_ok = is_dec;
            wide     = {4'd0, acc_reg} * 12'd10 + {8'd0, hex_d[3:0]};
        end
    end

    // advance the grammar by one character
    always_comb
    begin
        phase_step = phase_reg;
        acc_step   = acc_reg;
        emit       = 1'b0;
        case (phase_reg)
            PH_INIT:
            begin
                if (character_code == CH_LBRACE)
                    phase_step = PH_NEXT_VALUE;
                else if (character_code != CH_SPACE)
                    phase_step = PH_ERROR;
            end
            PH_NEXT_VALUE:
            begin
                if (character_code == CH_SPACE)
                    phase_step = PH_NEXT_VALUE;
                else if (character_code == CH_ZERO)
                    phase_step = PH_HEX_0;
                else if (character_code inside {[CH_ONE:CH_NINE]})
                begin
                    phase_step = PH_DEC_VALUE;
                    acc_step   = {4'd0, hex_d[3:0]};
                end
                else if (character_code == CH_RBRACE)
                    phase_step = PH_FIN;
                else
                    phase_step = PH_ERROR;
            end
            PH_HEX_0:
            begin
                phase_step = (character_code == CH_LOW_X) ? PH_HEX_X : PH_ERROR;
            end
            PH_HEX_X:
            begin
                if (!hex_d[4])
                begin
                    phase_step = PH_HEX_VALUE;
                    acc_step   = {4'd0, hex_d[3:0]};
                end
                else
                    phase_step = PH_ERROR;
            end
            PH_DEC_VALUE, PH_HEX_VALUE:
            begin
                if (digit_ok)
                begin
                    if (wide > BYTE_MAX)
                        phase_step = PH_ERROR;
                    else
                        acc_step = wide[7:0];
                end
                else if (character_code == CH_SPACE)
                begin
                    emit       = 1'b1;
                    phase_step = PH_VALUE_FIN;
                end
                else if (character_code == CH_COMMA)
                begin
                    emit       = 1'b1;
                    phase_step = PH_NEXT_VALUE;
                end
                else if (character_code == CH_RBRACE)
                begin
                    emit       = 1'b1;
                    phase_step = PH_FIN;
                end
                else
                    phase_step = PH_ERROR;
            end
            PH_VALUE_FIN:
            begin
                if (character_code == CH_SPACE)
                    phase_step = PH_VALUE_FIN;
                else if (character_code == CH_RBRACE)
                    phase_step = PH_FIN;
                else if (character_code == CH_COMMA)
                    phase_step = PH_NEXT_VALUE;
                else
                    phase_step = PH_ERROR;
            end
            PH_FIN:
                phase_step = PH_FIN;
            PH_ERROR:
                phase_step = PH_ERROR;
            default:
                phase_step = PH_ERROR;
        endcase
    end

    // build the record; clear the value once sent, restart after the last one
    always_comb
    begin
        phase_next       = phase_step;
        acc_next         = emit ? 8'd0 : acc_step;
        push_op.has_byte = emit;
        push_op.value    = acc_reg;
        push_op.has_end  = last_character;
        push_op.end_ok   = (phase_step == PH_FIN);
        if (last_character)
        begin
            phase_next = PH_INIT;
            acc_next   = 8'd0;
        end
    end

    assign push = accept && (emit || last_character);

    // hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INIT;
            acc_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ===== rtl/bbl_queue.sv =====
// ----------------------------------------------------------------------------
// bbl_queue
// Short register queue of parser records between the front and the back.
// ----------------------------------------------------------------------------
module bbl_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bbl_pkg::op_t  push_op,
    input  logic          pop,
    output bbl_pkg::op_t  pop_op,
    output logic          not_empty,
    output logic          full
);
    import bbl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    op_t            slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign pop_op    = slot_reg[rd_ptr_reg];

    // advance pointers with wrap, track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store incoming record
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ===== rtl/bbl_back.sv =====
// ----------------------------------------------------------------------------
// bbl_back
// Drains parser records into the output register: the byte first, then the
// end marker when the record carries both.
// ----------------------------------------------------------------------------
module bbl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  bbl_pkg::op_t  q_op,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    item_kind,
    output logic [7:0]    byte_value
);
    import bbl_pkg::*;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic [7:0] value_reg;
    logic [7:0] value_next;
    logic       pend_reg;
    logic       pend_next;
    logic       pend_ok_reg;
    logic       pend_ok_next;
    logic       load;

    assign load = !out_valid_reg || !out_stall;
    assign pop  = load && !pend_reg && q_not_empty;

    // pick the next result: pending end, else the head record
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        pend_next      = pend_reg;
        pend_ok_next   = pend_ok_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                kind_next      = pend_ok_reg ? KIND_OK : KIND_FAIL;
                value_next     = 8'd0;
                pend_next      = 1'b0;
            end
            else if (q_not_empty)
            begin
                out_valid_next = 1'b1;
                if (q_op.has_byte)
                begin
                    kind_next    = KIND_BYTE;
                    value_next   = q_op.value;
                    pend_next    = q_op.has_end;
                    pend_ok_next = q_op.end_ok;
                end
                else
                begin
                    kind_next  = q_op.end_ok ? KIND_OK : KIND_FAIL;
                    value_next = 8'd0;
                end
            end
            else
                out_valid_next = 1'b0;
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        pend_ok_reg <= pend_ok_next;
    end

    assign out_valid  = out_valid_reg;
    assign item_kind  = kind_reg;
    assign byte_value = value_reg;

endmodule

// ===== rtl/brace_byte_list_parser.sv =====
// ----------------------------------------------------------------------------
// brace_byte_list_parser
// Parses a brace-enclosed list of decimal and hex byte values, one character
// per cycle unless in_stall, and emits each byte and an end marker per string.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless the record queue is full.
// A record is written to the queue on the character's accept, then loaded
// into the output register. A character that ends both a byte and the string
// gives two results, the byte and then the end marker; no record goes between.
// Reset clears parser phase, accumulator, queue fill and output valid.
// ----------------------------------------------------------------------------
module brace_byte_list_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] character_code,
    input  logic       last_character,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] item_kind,
    output logic [7:0] byte_value
);
    import bbl_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    op_t  push_op;
    op_t  pop_op;

    assign in_stall = q_full;

    // classify characters and track the grammar
    bbl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .character_code (character_code),
        .last_character (last_character),
        .q_full         (q_full),
        .push           (push),
        .push_op        (push_op)
    );

    // decouple front and back
    bbl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .pop_op    (pop_op),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // sequence results onto the output
    bbl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_op        (pop_op),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .item_kind   (item_kind),
        .byte_value  (byte_value)
    );

endmodule

// ===== sim/brace_byte_list_parser_test.sv =====
// ----------------------------------------------------------------------------
// brace_byte_list_parser_test
// Drives brace-enclosed byte lists into the parser one character per request.
// A short table of directed strings comes first, then random lists, broken
// lists and noise. A character-level model of the parser predicts each byte
// and end item, save the end items of typed directed rows, which the table
// gives; each accepted result is checked in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module brace_byte_list_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bbl_pkg::*;

    localparam int CHAR_TARGET   = 850;
    localparam int IDLE_PCT      = 36;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIR_ROWS      = 7;

    // parser phases as the model tracks them
    typedef enum logic [3:0] {
        PH_WAIT_OPEN,
        PH_NEXT,
        PH_DEC,
        PH_ZERO,
        PH_HEX_PREFIX,
        PH_HEX,
        PH_AFTER_VALUE,
        PH_BAD,
        PH_CLOSED
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } list_item_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] character_code;
    logic       last_character;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] item_kind;
    logic [7:0] byte_value;

    // model state
    phase_t     parse_phase = PH_WAIT_OPEN;
    logic [7:0] value_acc   = 8'd0;

    list_item_t pending_items[$];
    logic [7:0] text_q[$];
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    bit         quiet          = 1'b0;
    bit         row_typed      = 1'b0;

    // directed strings; typed rows carry their end kind, the rest use the model
    string      dir_text  [DIR_ROWS] = '{"x", " {}", "{255,}", "{0xfF }z", "{0X}",
                                         "{256}", "{0x0"};
    bit         dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    logic [1:0] dir_end   [DIR_ROWS] = '{KIND_FAIL, KIND_OK, KIND_OK, KIND_OK,
                                         KIND_FAIL, KIND_FAIL, KIND_FAIL};

    brace_byte_list_parser DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .character_code (character_code),
        .last_character (last_character),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .byte_value     (byte_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // value of a hex digit, 16 when the character is not one
    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    // append one character to the text
    function automatic void add_char(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    // append one result to the expected list
    function automatic void expect_item(input list_item_t item);
        pending_items.insert(pending_items.size(), item);
    endfunction

    // advance the parser model by one character; return the number of results
    function automatic int parse_char(input logic [7:0] c, input logic last,
                                      output list_item_t first_item,
                                      output list_item_t second_item);
        int         count;
        bit         emit;
        logic [4:0] digit;
        int         wide;
        count       = 0;
        emit        = 1'b0;
        first_item  = '0;
        second_item = '0;
        case (parse_phase)
            PH_WAIT_OPEN:
            begin
                if (c == "{")
                    parse_phase = PH_NEXT;
                else if (c != " ")
                    parse_phase = PH_BAD;
            end
            PH_NEXT:
            begin
                if (c == "0")
                    parse_phase = PH_ZERO;
                else if (c >= "1" && c <= "9")
                begin
                    parse_phase = PH_DEC;
                    value_acc   = c - "0";
                end
                else if (c == "}")
                    parse_phase = PH_CLOSED;
                else if (c != " ")
                    parse_phase = PH_BAD;
            end
            PH_ZERO:
                parse_phase = (c == "x") ? PH_HEX_PREFIX : PH_BAD;
            PH_HEX_PREFIX:
            begin
                digit = hex_digit_value(c);
                if (digit < 16)
                begin
                    parse_phase = PH_HEX;
                    value_acc   = {4'd0, digit[3:0]};
                end
                else
                    parse_phase = PH_BAD;
            end
            PH_DEC, PH_HEX:
            begin
                if (parse_phase == PH_HEX)
                    digit = hex_digit_value(c);
                else
                    digit = (c >= "0" && c <= "9") ? 5'(c - "0") : 5'd16;
                if (digit < 16)
                begin
                    wide = int'(value_acc) * ((parse_phase == PH_HEX) ? 16 : 10) + digit;
                    if (wide > 255)
                        parse_phase = PH_BAD;
                    else
                        value_acc = wide[7:0];
                end
                else if (c == " ")
                begin
                    emit        = 1'b1;
                    parse_phase = PH_AFTER_VALUE;
                end
                else if (c == ",")
                begin
                    emit        = 1'b1;
                    parse_phase = PH_NEXT;
                end
                else if (c == "}")
                begin
                    emit        = 1'b1;
                    parse_phase = PH_CLOSED;
                end
                else
                    parse_phase = PH_BAD;
            end
            PH_AFTER_VALUE:
            begin
                if (c == "}")
                    parse_phase = PH_CLOSED;
                else if (c == ",")
                    parse_phase = PH_NEXT;
                else if (c != " ")
                    parse_phase = PH_BAD;
            end
            PH_CLOSED:
                ;
            default:
                parse_phase = PH_BAD;
        endcase

        // byte first, then the end item; the end returns the parser to reset
        if (emit)
        begin
            first_item = '{kind: KIND_BYTE, value: value_acc};
            value_acc  = 8'd0;
            count      = 1;
        end
        if (last)
        begin
            if (count == 0)
                first_item = '{kind: (parse_phase == PH_CLOSED) ? KIND_OK : KIND_FAIL,
                               value: 8'd0};
            else
                second_item = '{kind: (parse_phase == PH_CLOSED) ? KIND_OK : KIND_FAIL,
                                value: 8'd0};
            count++;
            parse_phase = PH_WAIT_OPEN;
            value_acc   = 8'd0;
        end
        return count;
    endfunction

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // drop up to max_count spaces into the text
    function automatic void push_spaces(input int max_count);
        int count;
        count = $urandom_range(0, max_count);
        repeat (count)
            add_char(" ");
    endfunction

    // write a number in decimal or 0x hex, hex digits in random case
    function automatic void push_number(input int unsigned v, input bit as_hex);
        logic [7:0]  digits[$];
        int unsigned rest;
        int unsigned d;
        rest = v;
        if (as_hex)
        begin
            do
            begin
                d = rest % 16;
                if (d < 10)
                    digits.push_front(8'("0" + d));
                else if ($urandom_range(0, 1))
                    digits.push_front(8'("a" + d - 10));
                else
                    digits.push_front(8'("A" + d - 10));
                rest = rest / 16;
            end
            while (rest != 0);
            if ($urandom_range(0, 3) == 0)
                digits.push_front("0");
            add_char("0");
            add_char("x");
        end
        else
        begin
            do
            begin
                digits.push_front(8'("0" + rest % 10));
                rest = rest / 10;
            end
            while (rest != 0);
        end
        foreach (digits[i])
            add_char(digits[i]);
    endfunction

    // build one random string: mostly well-formed lists, some broken, some noise
    function automatic void build_text();
        int mode;
        int value_count;
        int bad_slot;
        int damage;
        int pos;
        mode = $urandom_range(0, 99);
        text_q.delete();
        if (mode >= 85)
        begin
            // noise, sometimes behind an opening brace
            if ($urandom_range(0, 1))
                add_char("{");
            repeat ($urandom_range(1, 6))
                add_char(8'($urandom_range(0, 255)));
            return;
        end
        damage      = (mode >= 70) ? $urandom_range(0, 2) : -1;
        value_count = $urandom_range(0, 5);
        bad_slot    = (damage == 2 && value_count > 0) ? $urandom_range(0, value_count - 1) : -1;
        push_spaces(2);
        add_char("{");
        for (int i = 0; i < value_count; i++)
        begin
            push_spaces(2);
            if (i == bad_slot)
                push_number($urandom_range(0, 1) ? $urandom_range(256, 999)
                                                 : $urandom_range(256, 4095),
                            $urandom_range(0, 1));
            else if ($urandom_range(0, 1))
                push_number($urandom_range(0, 255), 1'b1);
            else
                push_number($urandom_range(1, 255), 1'b0);
            push_spaces(2);
            if (i != value_count - 1 || $urandom_range(0, 3) == 0)
                add_char(",");
        end
        push_spaces(2);
        add_char("}");
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                add_char(8'($urandom_range(0, 255)));

        // damage: one character replaced, or the string cut short
        if (damage == 0)
        begin
            pos         = $urandom_range(0, text_q.size() - 1);
            text_q[pos] = 8'($urandom_range(0, 255));
        end
        else if (damage == 1)
        begin
            pos = $urandom_range(1, text_q.size());
            while (text_q.size() > pos)
                void'(text_q.pop_back());
        end
    endfunction

    // entered at a falling edge; leave at the falling edge after the accept
    task automatic send_char(input logic [7:0] c, input logic last);
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        character_code <= c;
        last_character <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    // hold the sender until every expected result has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_items.size() != 0);
    endtask

    task automatic report_mismatch(input list_item_t want, input string what);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch %s: expected kind %0d byte %0d, got kind %0d byte %0d",
                     what, want.kind, want.value, item_kind, byte_value);
        mismatch_count++;
    endtask

    // randomize the output stall, with a quiet stretch
    always @(negedge clk)
        out_stall <= rst_n && idle_roll();

    // check results, predict on accepted requests, watch for a hang
    always @(posedge clk)
    begin
        list_item_t want;
        list_item_t first_item;
        list_item_t second_item;
        int         count;
        bit         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (pending_items.size() == 0)
                    report_mismatch('0, "(nothing expected)");
                else
                begin
                    want = pending_items.pop_front();
                    if (item_kind !== want.kind || byte_value !== want.value)
                        report_mismatch(want, "on result");
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                count = parse_char(character_code, last_character, first_item, second_item);
                if (!row_typed)
                begin
                    if (count > 0)
                        expect_item(first_item);
                    if (count > 1)
                        expect_item(second_item);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("brace_byte_list_parser verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int strings_sent;
        int chars_sent;
        in_valid       = 1'b0;
        character_code = 8'd0;
        last_character = 1'b0;
        out_stall      = 1'b0;
        rst_n          = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row_typed = dir_typed[r];
            if (row_typed)
                expect_item('{kind: dir_end[r], value: 8'd0});
            text_q.delete();
            for (int i = 0; i < dir_text[r].len(); i++)
                add_char(dir_text[r][i]);
            send_text();
        end
        row_typed = 1'b0;
        wait_for_drain();

        // random lists, broken lists and noise
        strings_sent = 0;
        chars_sent   = 0;
        while (chars_sent < CHAR_TARGET)
        begin
            quiet = (strings_sent >= 40 && strings_sent < 70);
            if (strings_sent == 100)
                wait_for_drain();
            build_text();
            send_text();
            chars_sent += text_q.size();
            strings_sent++;
        end
        quiet = 1'b0;

        // drain, then allow the pipeline to settle
        in_valid <= 1'b0;
        while (pending_items.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_items.size() == 0)
            $display("brace_byte_list_parser verification clean");
        else
            $display("brace_byte_list_parser verification failed");
        $finish;
    end

endmodule
